// ===== rtl/bmu_pkg.sv =====
package bmu_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned MODE_W     = 5;
  localparam int unsigned SHAMT_W    = 5;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CLPROD_W   = 2 * XLEN - 1;

  typedef enum logic [MODE_W-1:0] {
    OP_SH1ADD = 5'd0,
    OP_SH2ADD = 5'd1,
    OP_SH3ADD = 5'd2,
    OP_ANDN   = 5'd3,
    OP_ORN    = 5'd4,
    OP_XNOR   = 5'd5,
    OP_CLZ    = 5'd6,
    OP_CTZ    = 5'd7,
    OP_CPOP   = 5'd8,
    OP_SEXTB  = 5'd9,
    OP_SEXTH  = 5'd10,
    OP_ROL    = 5'd11,
    OP_ROR    = 5'd12,
    OP_MIN    = 5'd13,
    OP_MINU   = 5'd14,
    OP_MAX    = 5'd15,
    OP_MAXU   = 5'd16,
    OP_ORCB   = 5'd17,
    OP_REV8   = 5'd18,
    OP_ZEXTH  = 5'd19,
    OP_CLMUL  = 5'd20,
    OP_CLMULR = 5'd21,
    OP_CLMULH = 5'd22,
    OP_BSET   = 5'd23,
    OP_BCLR   = 5'd24,
    OP_BEXT   = 5'd25,
    OP_BINV   = 5'd26
  } op_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [XLEN-1:0]   operand_a;
    logic [XLEN-1:0]   operand_b;
  } in_t;

  typedef struct packed {
    logic [XLEN-1:0] result_value;
    logic            supported;
  } out_t;

endpackage

// ===== rtl/bmu_clmul.sv =====
module bmu_clmul (
  input  logic [bmu_pkg::XLEN-1:0]     a_i,
  input  logic [bmu_pkg::XLEN-1:0]     b_i,
  output logic [bmu_pkg::CLPROD_W-1:0] prod_o
);

  always_comb begin
    logic [bmu_pkg::XLEN-1:0] terms;
    prod_o = '0;
    for (int k = 0; k < int'(bmu_pkg::CLPROD_W); k++) begin
      terms = '0;
      for (int i = 0; i < int'(bmu_pkg::XLEN); i++) begin
        if ((k - i >= 0) && (k - i < int'(bmu_pkg::XLEN))) begin
          terms[i] = b_i[i] & a_i[k-i];
        end
      end
      prod_o[k] = ^terms;
    end
  end

endmodule

// ===== rtl/bmu_alu.sv =====
module bmu_alu (
  input  bmu_pkg::in_t  in_i,
  output bmu_pkg::out_t out_o
);

  logic [bmu_pkg::XLEN-1:0]     a;
  logic [bmu_pkg::XLEN-1:0]     b;
  logic [bmu_pkg::SHAMT_W-1:0]  shamt;
  logic [bmu_pkg::XLEN-1:0]     bit_mask;
  logic [2*bmu_pkg::XLEN-1:0]   rol_wide;
  logic [2*bmu_pkg::XLEN-1:0]   ror_wide;
  logic [bmu_pkg::CLPROD_W-1:0] cl_prod;
  logic [bmu_pkg::CNT_W-1:0]    clz_cnt;
  logic [bmu_pkg::CNT_W-1:0]    ctz_cnt;
  logic [bmu_pkg::CNT_W-1:0]    pop_cnt;
  logic [3:0]                   byte_pop [4];
  logic [bmu_pkg::XLEN-1:0]     orc_val;
  logic                         lt_s;
  logic                         lt_u;

  assign a        = in_i.operand_a;
  assign b        = in_i.operand_b;
  assign shamt    = b[bmu_pkg::SHAMT_W-1:0];
  assign bit_mask = bmu_pkg::XLEN'(1) << shamt;
  assign rol_wide = {a, a} << shamt;
  assign ror_wide = {a, a} >> shamt;
  assign lt_s     = $signed(a) < $signed(b);
  assign lt_u     = a < b;

  bmu_clmul u_clmul (
    .a_i    (a),
    .b_i    (b),
    .prod_o (cl_prod)
  );

  always_comb begin
    clz_cnt = bmu_pkg::CNT_W'(bmu_pkg::XLEN);
    for (int i = 0; i < int'(bmu_pkg::XLEN); i++) begin
      if (a[i]) begin
        clz_cnt = bmu_pkg::CNT_W'(int'(bmu_pkg::XLEN) - 1 - i);
      end
    end
  end

  always_comb begin
    ctz_cnt = bmu_pkg::CNT_W'(bmu_pkg::XLEN);
    for (int i = int'(bmu_pkg::XLEN) - 1; i >= 0; i--) begin
      if (a[i]) begin
        ctz_cnt = bmu_pkg::CNT_W'(i);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      byte_pop[k] = '0;
      for (int i = 0; i < 8; i++) begin
        byte_pop[k] = byte_pop[k] + 4'(a[8*k+i]);
      end
      orc_val[8*k +: 8] = {8{|a[8*k +: 8]}};
    end
    pop_cnt = (bmu_pkg::CNT_W'(byte_pop[0]) + bmu_pkg::CNT_W'(byte_pop[1]))
            + (bmu_pkg::CNT_W'(byte_pop[2]) + bmu_pkg::CNT_W'(byte_pop[3]));
  end

  always_comb begin
    out_o.supported    = 1'b1;
    out_o.result_value = '0;
    case (in_i.mode)
      bmu_pkg::OP_SH1ADD: out_o.result_value = (a << 1) + b;
      bmu_pkg::OP_SH2ADD: out_o.result_value = (a << 2) + b;
      bmu_pkg::OP_SH3ADD: out_o.result_value = (a << 3) + b;
      bmu_pkg::OP_ANDN:   out_o.result_value = a & ~b;
      bmu_pkg::OP_ORN:    out_o.result_value = a | ~b;
      bmu_pkg::OP_XNOR:   out_o.result_value = ~(a ^ b);
      bmu_pkg::OP_CLZ:    out_o.result_value = bmu_pkg::XLEN'(clz_cnt);
      bmu_pkg::OP_CTZ:    out_o.result_value = bmu_pkg::XLEN'(ctz_cnt);
      bmu_pkg::OP_CPOP:   out_o.result_value = bmu_pkg::XLEN'(pop_cnt);
      bmu_pkg::OP_SEXTB:  out_o.result_value = {{24{a[7]}}, a[7:0]};
      bmu_pkg::OP_SEXTH:  out_o.result_value = {{16{a[15]}}, a[15:0]};
      bmu_pkg::OP_ROL:    out_o.result_value = rol_wide[2*bmu_pkg::XLEN-1:bmu_pkg::XLEN];
      bmu_pkg::OP_ROR:    out_o.result_value = ror_wide[bmu_pkg::XLEN-1:0];
      bmu_pkg::OP_MIN:    out_o.result_value = lt_s ? a : b;
      bmu_pkg::OP_MINU:   out_o.result_value = lt_u ? a : b;
      bmu_pkg::OP_MAX:    out_o.result_value = lt_s ? b : a;
      bmu_pkg::OP_MAXU:   out_o.result_value = lt_u ? b : a;
      bmu_pkg::OP_ORCB:   out_o.result_value = orc_val;
      bmu_pkg::OP_REV8:   out_o.result_value = {a[7:0], a[15:8], a[23:16], a[31:24]};
      bmu_pkg::OP_ZEXTH:  out_o.result_value = {16'h0000, a[15:0]};
      bmu_pkg::OP_CLMUL:  out_o.result_value = cl_prod[bmu_pkg::XLEN-1:0];
      bmu_pkg::OP_CLMULR: out_o.result_value = cl_prod[2*bmu_pkg::XLEN-2:bmu_pkg::XLEN-1];
      bmu_pkg::OP_CLMULH: out_o.result_value =
                            {1'b0, cl_prod[2*bmu_pkg::XLEN-2:bmu_pkg::XLEN]};
      bmu_pkg::OP_BSET:   out_o.result_value = a | bit_mask;
      bmu_pkg::OP_BCLR:   out_o.result_value = a & ~bit_mask;
      bmu_pkg::OP_BEXT:   out_o.result_value = {{(bmu_pkg::XLEN-1){1'b0}}, a[shamt]};
      bmu_pkg::OP_BINV:   out_o.result_value = a ^ bit_mask;
      default: begin
        out_o.supported    = 1'b0;
        out_o.result_value = '0;
      end
    endcase
  end

endmodule

// ===== rtl/rv32_bitmanip_alu_core.sv =====
// Data path: an accepted input item goes into the input register, then its result into the result
// register, which drives the output; a stall on the output can hold an item in either register.
// Throughput: one item per cycle while the output is not stalled; the result register frees as its item is taken.
// Reset clears both stage valid flags; no item is held after reset.
module rv32_bitmanip_alu_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bmu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bmu_pkg::out_t out_data_o
);

  logic          s1_valid_q, s1_valid_d;
  bmu_pkg::in_t  s1_data_q;
  logic          s2_valid_q, s2_valid_d;
  bmu_pkg::out_t s2_data_q;
  bmu_pkg::out_t alu_res;
  logic          s1_ready;
  logic          s2_ready;

  assign s2_ready   = !s2_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  assign s1_valid_d = s1_ready ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_ready ? s1_valid_q : s2_valid_q;

  bmu_alu u_alu (
    .in_i  (s1_data_q),
    .out_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_data_q <= in_data_i;
    end
    if (s1_valid_q && s2_ready) begin
      s2_data_q <= alu_res;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

  a_in_to_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_valid_q)
    else $error("accepted item not held in input register");

  a_s1_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> out_valid_o)
    else $error("advanced item not presented at output");

  a_supported : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=>
      out_data_o.supported == ($past(s1_data_q.mode) <= bmu_pkg::OP_BINV))
    else $error("supported flag does not match operation code");

  a_unsup_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.supported |-> out_data_o.result_value == '0)
    else $error("unsupported operation gave nonzero result");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [bmu_pkg::MODE_W-1:0] MODE_TOP = '1;

  typedef struct packed {
    bmu_pkg::in_t  stim;
    logic          known;
    bmu_pkg::out_t res;
  } bmu_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bmu_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bmu_pkg::out_t out_data;
  logic calm = 1'b0;

  bmu_pkg::out_t result_q[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   unsupported_seen = 0;

  bmu_row_t directed_rows [28] = '{
    '{'{bmu_pkg::OP_SH1ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{bmu_pkg::OP_SH2ADD, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'h0000_0000, 1'b1}},
    '{'{bmu_pkg::OP_SH3ADD, 32'h1234_5678, 32'h0000_0009}, 1'b0, '0},
    '{'{bmu_pkg::OP_ANDN,   32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
    '{'{bmu_pkg::OP_ORN,    32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
    '{'{bmu_pkg::OP_XNOR,   32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
    '{'{bmu_pkg::OP_CLZ,    32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, '{32'd32, 1'b1}},
    '{'{bmu_pkg::OP_CTZ,    32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, '{32'd32, 1'b1}},
    '{'{bmu_pkg::OP_CPOP,   32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{32'd32, 1'b1}},
    '{'{bmu_pkg::OP_SEXTB,  32'h0000_0080, 32'hFFFF_FFFF}, 1'b1, '{32'hFFFF_FF80, 1'b1}},
    '{'{bmu_pkg::OP_SEXTH,  32'h0000_8000, 32'h0000_0000}, 1'b1, '{32'hFFFF_8000, 1'b1}},
    '{'{bmu_pkg::OP_ROL,    32'h8000_0001, 32'hFFFF_FFE1}, 1'b0, '0},
    '{'{bmu_pkg::OP_ROR,    32'h1234_5678, 32'h0000_0020}, 1'b1, '{32'h1234_5678, 1'b1}},
    '{'{bmu_pkg::OP_MIN,    32'h8000_0000, 32'h7FFF_FFFF}, 1'b1, '{32'h8000_0000, 1'b1}},
    '{'{bmu_pkg::OP_MINU,   32'h8000_0000, 32'h7FFF_FFFF}, 1'b1, '{32'h7FFF_FFFF, 1'b1}},
    '{'{bmu_pkg::OP_MAX,    32'h8000_0000, 32'h7FFF_FFFF}, 1'b1, '{32'h7FFF_FFFF, 1'b1}},
    '{'{bmu_pkg::OP_MAXU,   32'h8000_0000, 32'h7FFF_FFFF}, 1'b1, '{32'h8000_0000, 1'b1}},
    '{'{bmu_pkg::OP_ORCB,   32'h0001_0080, 32'h0000_0000}, 1'b1, '{32'h00FF_00FF, 1'b1}},
    '{'{bmu_pkg::OP_REV8,   32'h1122_3344, 32'h0000_0000}, 1'b1, '{32'h4433_2211, 1'b1}},
    '{'{bmu_pkg::OP_ZEXTH,  32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{32'h0000_FFFF, 1'b1}},
    '{'{bmu_pkg::OP_CLMUL,  32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{bmu_pkg::OP_CLMULR, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{bmu_pkg::OP_CLMULH, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{bmu_pkg::OP_BSET,   32'h0000_0000, 32'hFFFF_FFFF}, 1'b1, '{32'h8000_0000, 1'b1}},
    '{'{bmu_pkg::OP_BCLR,   32'hFFFF_FFFF, 32'h0000_0000}, 1'b1, '{32'hFFFF_FFFE, 1'b1}},
    '{'{bmu_pkg::OP_BEXT,   32'h8000_0000, 32'h0000_003F}, 1'b1, '{32'h0000_0001, 1'b1}},
    '{'{bmu_pkg::OP_BINV,   32'h0000_0000, 32'h0000_0020}, 1'b1, '{32'h0000_0001, 1'b1}},
    '{'{MODE_TOP,           32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{32'h0000_0000, 1'b0}}
  };

  rv32_bitmanip_alu_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic bmu_pkg::out_t bmu_predict(input bmu_pkg::in_t it);
    bmu_pkg::out_t r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] bitmask;
    logic [4:0]  idx;
    logic [63:0] prod;
    int          n;
    a = it.operand_a;
    b = it.operand_b;
    idx = b[4:0];
    bitmask = 32'h1 << idx;
    prod = '0;
    for (int i = 0; i < 32; i++) begin
      if (b[i]) prod ^= {32'h0, a} << i;
    end
    n = 0;
    r.result_value = '0;
    r.supported = 1'b1;
    case (it.mode)
      bmu_pkg::OP_SH1ADD: r.result_value = (a << 1) + b;
      bmu_pkg::OP_SH2ADD: r.result_value = (a << 2) + b;
      bmu_pkg::OP_SH3ADD: r.result_value = (a << 3) + b;
      bmu_pkg::OP_ANDN:   r.result_value = a & ~b;
      bmu_pkg::OP_ORN:    r.result_value = a | ~b;
      bmu_pkg::OP_XNOR:   r.result_value = ~(a ^ b);
      bmu_pkg::OP_CLZ: begin
        while (n < 32 && !a[31 - n]) n++;
        r.result_value = n;
      end
      bmu_pkg::OP_CTZ: begin
        while (n < 32 && !a[n]) n++;
        r.result_value = n;
      end
      bmu_pkg::OP_CPOP:   r.result_value = $countones(a);
      bmu_pkg::OP_SEXTB:  r.result_value = {{24{a[7]}}, a[7:0]};
      bmu_pkg::OP_SEXTH:  r.result_value = {{16{a[15]}}, a[15:0]};
      bmu_pkg::OP_ROL:    r.result_value = (a << idx) | (a >> (32 - idx));
      bmu_pkg::OP_ROR:    r.result_value = (a >> idx) | (a << (32 - idx));
      bmu_pkg::OP_MIN:    r.result_value = ($signed(a) < $signed(b)) ? a : b;
      bmu_pkg::OP_MINU:   r.result_value = (a < b) ? a : b;
      bmu_pkg::OP_MAX:    r.result_value = ($signed(b) < $signed(a)) ? a : b;
      bmu_pkg::OP_MAXU:   r.result_value = (a > b) ? a : b;
      bmu_pkg::OP_ORCB: begin
        for (int k = 0; k < 4; k++) r.result_value[8*k +: 8] = {8{|a[8*k +: 8]}};
      end
      bmu_pkg::OP_REV8:   r.result_value = {a[7:0], a[15:8], a[23:16], a[31:24]};
      bmu_pkg::OP_ZEXTH:  r.result_value = {16'h0, a[15:0]};
      bmu_pkg::OP_CLMUL:  r.result_value = prod[31:0];
      bmu_pkg::OP_CLMULR: r.result_value = prod[62:31];
      bmu_pkg::OP_CLMULH: r.result_value = prod[63:32];
      bmu_pkg::OP_BSET:   r.result_value = a | bitmask;
      bmu_pkg::OP_BCLR:   r.result_value = a & ~bitmask;
      bmu_pkg::OP_BEXT:   r.result_value = {31'h0, a[idx]};
      bmu_pkg::OP_BINV:   r.result_value = a ^ bitmask;
      default:            r.supported = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(0, 255);
      5:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic bmu_pkg::in_t pick_item();
    bmu_pkg::in_t it;
    if ($urandom_range(0, 9) == 0)
      it.mode = bmu_pkg::MODE_W'($urandom_range(bmu_pkg::OP_BINV + 1, MODE_TOP));
    else
      it.mode = bmu_pkg::MODE_W'($urandom_range(bmu_pkg::OP_SH1ADD, bmu_pkg::OP_BINV));
    it.operand_a = pick_word();
    it.operand_b = pick_word();
    return it;
  endfunction

  function automatic logic idle_roll();
    return !calm && ($urandom_range(0, 99) < 31);
  endfunction

  task automatic send_item(input bmu_pkg::in_t stim, input logic known,
                           input bmu_pkg::out_t res);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= stim;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    result_q.push_back(known ? res : bmu_predict(stim));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    wait (result_q.size() == 0);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : rx_side
    bmu_pkg::out_t want;
    if (out_valid && !out_stall) begin
      results_seen++;
      if (!out_data.supported) unsupported_seen++;
      if (result_q.size() == 0) begin
        $error("unexpected item: result_value %h supported %b",
               out_data.result_value, out_data.supported);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        if (out_data.result_value !== want.result_value) begin
          $error("result_value: expected %h, got %h", want.result_value,
                 out_data.result_value);
          mismatches++;
        end
        if (out_data.supported !== want.supported) begin
          $error("supported: expected %b, got %b", want.supported, out_data.supported);
          mismatches++;
        end
      end
    end
    out_stall <= idle_roll();
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].known, directed_rows[i].res);
    settle();
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // hold both sides busy through a long stretch
      calm <= (k >= 150 && k < 250);
      if (k == 350) settle();
      send_item(pick_item(), 1'b0, '0);
    end
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Checked %0d results across all 27 operations, %0d of them on unused codes.",
             results_seen, unsupported_seen);
    $display("Directed corners plus %0d random items with random gaps on both sides.",
             RANDOM_ITEMS);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== rv32_bitmanip_alu_core.f =====
rtl/bmu_pkg.sv
rtl/bmu_clmul.sv
rtl/bmu_alu.sv
rtl/rv32_bitmanip_alu_core.sv
verif/tb_top.sv
